@@ design/erpd_pkg.sv @@
`default_nettype none
package erpd_pkg;

  localparam int IDX_W  = 4;
  localparam int SIZE_W = 5;

  localparam logic [1:0] OP_PUBLISH = 2'd0;
  localparam logic [1:0] OP_DRAIN   = 2'd1;
  localparam logic [1:0] OP_RELEASE = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_IGNORED = 2'd2;
  localparam logic [1:0] ST_RANGE   = 2'd3;

  localparam logic [SIZE_W-1:0] RING_SIZE_RESET = 5'd16;
  localparam logic [SIZE_W-1:0] MIN_SIZE        = 5'd2;

  typedef struct packed {
    logic [63:0] timestamp;
    logic [63:0] type_tag;
    logic [63:0] corr_key;
    logic        corr_present;
    logic [15:0] body_len;
    logic [63:0] payload_word;
  } rec_t;

  typedef struct packed {
    logic accept;
    logic step;
    logic cfg_write;
  } ctrl_cmd_t;

  typedef struct packed {
    logic drain_run;
    logic step_last;
  } dp_status_t;

endpackage
`default_nettype wire

@@ design/erpd_ram.sv @@
`default_nettype none
module erpd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [AW-1:0]            waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [AW-1:0]            raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

@@ design/erpd_ctrl.sv @@
`default_nettype none
module erpd_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  input  wire logic                  cfg_valid,
  input  wire erpd_pkg::dp_status_t  st,
  output logic                       busy,
  output logic                       cfg_ready,
  output erpd_pkg::ctrl_cmd_t        cmd
);

  localparam logic S_IDLE  = 1'b0;
  localparam logic S_DRAIN = 1'b1;

  logic state;
  logic state_next;

  assign busy          = (state == S_DRAIN);
  // a size write never shares an edge with a command transfer
  assign cfg_ready     = (state == S_IDLE) && !start;
  assign cmd.accept    = start && !busy;
  assign cmd.step      = (state == S_DRAIN);
  assign cmd.cfg_write = cfg_valid && cfg_ready;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (cmd.accept && st.drain_run) state_next = S_DRAIN;
      end
      S_DRAIN: begin
        if (st.step_last) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

`ifndef SYNTHESIS
  a_drain_enters_walk: assert property (@(posedge clk) disable iff (rst)
    (cmd.accept && st.drain_run) |=> (state == S_DRAIN))
    else $error("drain with records did not start the walk");
`endif

endmodule
`default_nettype wire

@@ design/erpd_datapath.sv @@
`default_nettype none
module erpd_datapath #(
  parameter int SLOTS       = 16,
  parameter int MAX_PAYLOAD = 256
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire erpd_pkg::ctrl_cmd_t  cmd,
  output erpd_pkg::dp_status_t      st,
  input  wire logic [4:0]           ring_size,
  input  wire logic [1:0]           operation,
  input  wire logic [63:0]          timestamp,
  input  wire logic [63:0]          type_tag,
  input  wire logic [63:0]          corr_key,
  input  wire logic                 corr_present,
  input  wire logic [15:0]          body_len,
  input  wire logic [63:0]          payload_word,
  input  wire logic [3:0]           cursor,
  input  wire logic [3:0]           max_count,
  input  wire logic                 count_only,
  output logic                      result_strobe,
  output logic [1:0]                status,
  output logic                      rec_valid,
  output logic [63:0]               rec_timestamp,
  output logic [63:0]               rec_type_tag,
  output logic [63:0]               rec_corr_key,
  output logic                      rec_corr_present,
  output logic [15:0]               rec_body_len,
  output logic [63:0]               rec_payload_word,
  output logic [3:0]                drained_count,
  output logic [3:0]                new_cursor,
  output logic                      last
);

  localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int RW = $bits(erpd_pkg::rec_t);
  localparam logic [erpd_pkg::SIZE_W-1:0] SIZE_TOP = erpd_pkg::SIZE_W'(SLOTS);
  localparam logic [15:0] PLEN_TOP = 16'(MAX_PAYLOAD);

  function automatic logic [63:0] cut_at_nul(input logic [63:0] tag);
    logic [63:0] keep;
    logic        alive;
    keep  = '0;
    alive = 1'b1;
    for (int b = 0; b < 8; b++) begin
      if (tag[8*b +: 8] == 8'd0) alive = 1'b0;
      if (alive) keep[8*b +: 8] = tag[8*b +: 8];
    end
    return keep;
  endfunction

  logic [erpd_pkg::SIZE_W-1:0] size_cfg;
  logic [erpd_pkg::IDX_W-1:0]  head;
  logic [erpd_pkg::IDX_W-1:0]  tail;
  logic [erpd_pkg::IDX_W-1:0]  walk_idx;
  logic [erpd_pkg::IDX_W-1:0]  walk_cnt;
  logic [erpd_pkg::IDX_W-1:0]  walk_rem;
  logic [SLOTS-1:0]            vld;
  logic                        rd_vld;
  logic                        rec_sel;

  logic [erpd_pkg::SIZE_W-1:0] size_w;
  logic [erpd_pkg::SIZE_W-1:0] cur5;
  logic [erpd_pkg::SIZE_W-1:0] head5;
  logic [erpd_pkg::SIZE_W-1:0] tail5;
  logic                        in_range;
  logic [erpd_pkg::SIZE_W-1:0] head_inc;
  logic [erpd_pkg::IDX_W-1:0]  head_nxt;
  logic                        full;
  logic [15:0]                 plen_sat;
  logic [63:0]                 word_masked;
  erpd_pkg::rec_t              wr_rec;
  erpd_pkg::rec_t              rd_rec;
  erpd_pkg::rec_t              rec_out;
  logic [erpd_pkg::SIZE_W-1:0] dist_h;
  logic [erpd_pkg::SIZE_W-1:0] n5;
  logic [erpd_pkg::SIZE_W-1:0] fin5;
  logic [erpd_pkg::IDX_W-1:0]  fin;
  logic [erpd_pkg::SIZE_W-1:0] live;
  logic [erpd_pkg::SIZE_W-1:0] dist_t;
  logic                        rel_ok;
  logic [erpd_pkg::SIZE_W-1:0] idx_inc;
  logic [erpd_pkg::IDX_W-1:0]  idx_wrap;
  logic                        ram_we;

  // working size clamped to between two and the slots that exist
  always_comb begin
    if (size_cfg < erpd_pkg::MIN_SIZE) size_w = erpd_pkg::MIN_SIZE;
    else if (size_cfg > SIZE_TOP)      size_w = SIZE_TOP;
    else                               size_w = size_cfg;
  end

  assign cur5     = {1'b0, cursor};
  assign head5    = {1'b0, head};
  assign tail5    = {1'b0, tail};
  assign in_range = (cur5 < size_w);

  // publish
  assign head_inc = head5 + 5'd1;
  assign head_nxt = (head_inc >= size_w) ? '0 : head_inc[erpd_pkg::IDX_W-1:0];
  assign full     = (head_nxt == tail);
  assign plen_sat = (body_len > PLEN_TOP) ? PLEN_TOP : body_len;

  always_comb begin
    word_masked = payload_word;
    for (int b = 0; b < 8; b++) begin
      if (16'(b) >= plen_sat) word_masked[8*b +: 8] = 8'd0;
    end
  end

  always_comb begin
    wr_rec.timestamp    = timestamp;
    wr_rec.type_tag     = cut_at_nul(type_tag);
    wr_rec.corr_key     = corr_present ? corr_key : 64'd0;
    wr_rec.corr_present = corr_present;
    wr_rec.body_len     = plen_sat;
    wr_rec.payload_word = word_masked;
  end

  assign ram_we = cmd.accept && (operation == erpd_pkg::OP_PUBLISH) && !full;

  // drain: records between cursor and head, capped by max_count
  assign dist_h = (head >= cursor) ? (head5 - cur5) : (head5 + size_w - cur5);
  assign n5     = ({1'b0, max_count} < dist_h) ? {1'b0, max_count} : dist_h;
  assign fin5   = cur5 + n5;
  assign fin    = (fin5 >= size_w) ? erpd_pkg::IDX_W'(fin5 - size_w)
                                   : fin5[erpd_pkg::IDX_W-1:0];

  assign st.drain_run = (operation == erpd_pkg::OP_DRAIN) && in_range
                        && (n5 != '0) && !count_only;

  // release: cursor must lie within tail..head
  assign live   = (head >= tail) ? (head5 - tail5) : (head5 + size_w - tail5);
  assign dist_t = (cursor >= tail) ? (cur5 - tail5) : (cur5 + size_w - tail5);
  assign rel_ok = (dist_t <= live);

  // walk one slot per cycle
  assign idx_inc      = {1'b0, walk_idx} + 5'd1;
  assign idx_wrap     = (idx_inc >= size_w) ? '0 : idx_inc[erpd_pkg::IDX_W-1:0];
  assign st.step_last = (walk_rem == 4'd1);

  erpd_ram #(
    .WIDTH (RW),
    .DEPTH (SLOTS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (head[AW-1:0]),
    .wdata (wr_rec),
    .re    (cmd.step),
    .raddr (walk_idx[AW-1:0]),
    .rdata (rd_rec)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      size_cfg      <= erpd_pkg::RING_SIZE_RESET;
      head          <= '0;
      tail          <= '0;
      vld           <= '0;
      walk_rem      <= '0;
      result_strobe <= 1'b0;
      rec_sel       <= 1'b0;
    end else begin
      result_strobe <= (cmd.accept && !st.drain_run) || cmd.step;
      rec_sel       <= cmd.step;
      if (cmd.accept && st.drain_run) begin
        walk_rem <= n5[erpd_pkg::IDX_W-1:0];
      end else if (cmd.step) begin
        walk_rem <= walk_rem - 4'd1;
      end
      // writing the size empties the ring
      if (cmd.cfg_write) begin
        size_cfg <= ring_size;
        head     <= '0;
        tail     <= '0;
      end else begin
        if (ram_we) begin
          head                <= head_nxt;
          vld[head[AW-1:0]]   <= 1'b1;
        end
        if (cmd.accept && (operation == erpd_pkg::OP_RELEASE) && in_range && rel_ok) begin
          tail <= cursor;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && st.drain_run) begin
      walk_idx <= cursor;
      walk_cnt <= '0;
    end else if (cmd.step) begin
      walk_idx <= idx_wrap;
      walk_cnt <= walk_cnt + 4'd1;
    end

    if (cmd.step) begin
      status        <= erpd_pkg::ST_OK;
      drained_count <= walk_cnt + 4'd1;
      new_cursor    <= idx_wrap;
      last          <= st.step_last;
      rd_vld        <= vld[walk_idx[AW-1:0]];
    end else if (cmd.accept) begin
      last <= 1'b1;
      unique case (operation)
        erpd_pkg::OP_PUBLISH: begin
          status        <= full ? erpd_pkg::ST_FULL : erpd_pkg::ST_OK;
          drained_count <= '0;
          new_cursor    <= '0;
        end
        erpd_pkg::OP_DRAIN: begin
          if (!in_range) begin
            status        <= erpd_pkg::ST_RANGE;
            drained_count <= '0;
            new_cursor    <= cursor;
          end else begin
            status        <= erpd_pkg::ST_OK;
            drained_count <= n5[erpd_pkg::IDX_W-1:0];
            new_cursor    <= fin;
          end
        end
        erpd_pkg::OP_RELEASE: begin
          drained_count <= '0;
          if (!in_range) begin
            status     <= erpd_pkg::ST_RANGE;
            new_cursor <= cursor;
          end else begin
            status     <= rel_ok ? erpd_pkg::ST_OK : erpd_pkg::ST_IGNORED;
            new_cursor <= '0;
          end
        end
        default: begin
          status        <= erpd_pkg::ST_IGNORED;
          drained_count <= '0;
          new_cursor    <= '0;
        end
      endcase
    end
  end

  // slots never written read as zero
  assign rec_out          = (rec_sel && rd_vld) ? rd_rec : '0;
  assign rec_valid        = rec_sel;
  assign rec_timestamp    = rec_out.timestamp;
  assign rec_type_tag     = rec_out.type_tag;
  assign rec_corr_key     = rec_out.corr_key;
  assign rec_corr_present = rec_out.corr_present;
  assign rec_body_len     = rec_out.body_len;
  assign rec_payload_word = rec_out.payload_word;

`ifndef SYNTHESIS
  a_head_in_ring: assert property (@(posedge clk) disable iff (rst)
    head5 < size_w)
    else $error("head outside working ring");

  a_tail_in_ring: assert property (@(posedge clk) disable iff (rst)
    tail5 < size_w)
    else $error("tail outside working ring");

  a_walk_has_work: assert property (@(posedge clk) disable iff (rst)
    cmd.step |-> ((walk_rem != '0) && !ram_we))
    else $error("walk step with no records left or during a publish");
`endif

endmodule
`default_nettype wire

@@ design/event_ring_publish_drain.sv @@
`default_nettype none
// Event ring with head, tail and a caller-held read cursor.
// Command channel: an item is taken at a clock edge with start high and busy
// low; operation selects publish, drain or release. Results come out on the
// result ports, one per cycle marked by result_strobe, and last flags the
// final result of an item. The receiver cannot hold results off.
// Publish, release, out-of-range and unknown operations give one result in
// the cycle after the transfer and a new item may follow every cycle.
// A drain that returns n records (n > 0, count_only low) holds busy while the
// walk reads one slot per cycle from the slot RAM; the controller first enters
// its drain state, then each record passes the RAM read register and comes out
// one per cycle. A counting drain gives one result in the cycle after transfer.
// Configuration: ring_size is written over cfg_valid/cfg_ready while idle with
// start low and empties the ring (head and tail go to 0); stored slots keep
// their data.
// Reset (rst, synchronous) empties the ring, sets ring_size to 16 and makes
// every slot read as zero until written.
module event_ring_publish_drain #(
  parameter int DEPTH       = 16,
  parameter int MAX_PAYLOAD = 256
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [4:0]  ring_size,
  input  wire logic [1:0]  operation,
  input  wire logic [63:0] timestamp,
  input  wire logic [63:0] type_tag,
  input  wire logic [63:0] corr_key,
  input  wire logic        corr_present,
  input  wire logic [15:0] body_len,
  input  wire logic [63:0] payload_word,
  input  wire logic [3:0]  cursor,
  input  wire logic [3:0]  max_count,
  input  wire logic        count_only,
  output logic             result_strobe,
  output logic [1:0]       status,
  output logic             rec_valid,
  output logic [63:0]      rec_timestamp,
  output logic [63:0]      rec_type_tag,
  output logic [63:0]      rec_corr_key,
  output logic             rec_corr_present,
  output logic [15:0]      rec_body_len,
  output logic [63:0]      rec_payload_word,
  output logic [3:0]       drained_count,
  output logic [3:0]       new_cursor,
  output logic             last
);

  // cursors are four bits wide, so at most sixteen slots are used
  localparam int SLOTS = (DEPTH < 16) ? DEPTH : 16;

  erpd_pkg::ctrl_cmd_t  cmd;
  erpd_pkg::dp_status_t st;

  erpd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .cfg_valid (cfg_valid),
    .st        (st),
    .busy      (busy),
    .cfg_ready (cfg_ready),
    .cmd       (cmd)
  );

  erpd_datapath #(
    .SLOTS       (SLOTS),
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_datapath (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .st               (st),
    .ring_size        (ring_size),
    .operation        (operation),
    .timestamp        (timestamp),
    .type_tag         (type_tag),
    .corr_key         (corr_key),
    .corr_present     (corr_present),
    .body_len         (body_len),
    .payload_word     (payload_word),
    .cursor           (cursor),
    .max_count        (max_count),
    .count_only       (count_only),
    .result_strobe    (result_strobe),
    .status           (status),
    .rec_valid        (rec_valid),
    .rec_timestamp    (rec_timestamp),
    .rec_type_tag     (rec_type_tag),
    .rec_corr_key     (rec_corr_key),
    .rec_corr_present (rec_corr_present),
    .rec_body_len     (rec_body_len),
    .rec_payload_word (rec_payload_word),
    .drained_count    (drained_count),
    .new_cursor       (new_cursor),
    .last             (last)
  );

endmodule
`default_nettype wire
